// ===== rtl/agcm_pkg.sv =====
package agcm_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_KEY = 2'd0,
    OP_START    = 2'd1,
    OP_ENCRYPT  = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_HASH_KEY_HIGH = 2'd0,
    CFG_HASH_KEY_LOW  = 2'd1,
    CFG_IV_HIGH       = 2'd2,
    CFG_IV_LOW        = 2'd3
  } cfg_idx_t;

  localparam int unsigned KEY_WORDS = 60;
  localparam int unsigned KEY_IDX_W = 6;
  localparam logic [7:0] GF_REDUCE = 8'hE1;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  key_index;
    logic [31:0] key_word;
    logic [31:0] counter_value;
    logic [63:0] data_high;
    logic [63:0] data_low;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    logic [63:0] hash_high;
    logic [63:0] hash_low;
  } out_beat_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // state byte j sits at bits [127-8j -: 8]
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = sbox(s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // key word byte order is little-endian within the column
  function automatic logic [31:0] key_col(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

// ===== rtl/agcm_if.sv =====
interface agcm_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/agcm_ram.sv =====
module agcm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/agcm_ghash.sv =====
// bit-serial gf(2^128) multiply, 8 bits per cycle
module agcm_ghash (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] x,
  input  logic [127:0] h,
  output logic         done,
  output logic [127:0] z
);
  logic [127:0] z_r, z_nxt, v_r, v_nxt, x_r, x_nxt;
  logic [3:0]   cnt_r;
  logic         busy_r, done_r;

  always_comb begin
    z_nxt = z_r;
    v_nxt = v_r;
    x_nxt = x_r;
    for (int i = 0; i < 8; i++) begin
      if (x_nxt[127]) begin
        z_nxt = z_nxt ^ v_nxt;
      end
      v_nxt = {1'b0, v_nxt[127:1]} ^ (v_nxt[0] ? {agcm_pkg::GF_REDUCE, 120'd0} : 128'd0);
      x_nxt = {x_nxt[126:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      z_r <= '0;
      v_r <= h;
      x_r <= x;
    end else if (busy_r) begin
      z_r <= z_nxt;
      v_r <= v_nxt;
      x_r <= x_nxt;
    end
  end

  assign done = done_r;
  assign z    = z_r;
endmodule

// ===== rtl/aes256_gcm_block_encrypt.sv =====
// encrypt beat: the round steps read one key store word a cycle, then S_HASH starts ghash,
// S_WAIT waits for ghash done and S_OUT loads the result register; the next beat is accepted
// only back in S_IDLE, after the result register has taken this one, and S_OUT holds while
// the result register still holds an unaccepted beat
// key load and start beats are taken while idle and leave the block idle
// synchronous active-low reset clears counter, ghash accumulator, config and control, not keys
module aes256_gcm_block_encrypt #(
  parameter int unsigned AES_ROUNDS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  agcm_if.sink        in_ch,
  agcm_if.source      out_ch
);
  localparam int unsigned NWORDS = 4 * (AES_ROUNDS + 1);

  typedef enum logic [2:0] {S_IDLE, S_KEY, S_HASH, S_WAIT, S_OUT} state_t;

  state_t       state_r;
  logic [63:0]  hkh_r, hkl_r, ivh_r;
  logic [31:0]  ivl_r, ctr_r;
  logic [127:0] acc_r, st_r, pt_r, ct_r, round_key;
  logic [95:0]  rk_r;
  logic [5:0]   rd_addr_r;
  logic [5:0]   word_r;
  logic [31:0]  rdata;
  logic         gh_start, gh_done;
  logic [127:0] gh_z, rnd;
  logic         out_valid_r, ob_load;
  agcm_pkg::in_beat_t  ib;
  agcm_pkg::out_beat_t ob_r;

  assign ib = in_ch.data;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = ob_r;

  // result register takes a new beat once it is empty or being drained
  assign ob_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hkh_r <= '0; hkl_r <= '0; ivh_r <= '0; ivl_r <= '0;
    end else if (cfg_we) begin
      unique case (agcm_pkg::cfg_idx_t'(cfg_index))
        agcm_pkg::CFG_HASH_KEY_HIGH: hkh_r <= cfg_data;
        agcm_pkg::CFG_HASH_KEY_LOW:  hkl_r <= cfg_data;
        agcm_pkg::CFG_IV_HIGH:       ivh_r <= cfg_data;
        agcm_pkg::CFG_IV_LOW:        ivl_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic key_we;
  assign key_we = in_ch.valid && in_ch.ready && ib.op == agcm_pkg::OP_LOAD_KEY
                  && ib.key_index < 6'(agcm_pkg::KEY_WORDS);

  agcm_ram #(.WIDTH(32), .DEPTH(agcm_pkg::KEY_WORDS)) u_keys (
    .clk(clk), .we(key_we), .waddr(ib.key_index), .wdata(ib.key_word),
    .raddr(rd_addr_r), .rdata(rdata)
  );

  assign round_key = {rk_r, agcm_pkg::key_col(rdata)};

  // word_r counts read data arriving; on each 4th word a round key is complete
  logic [5:0] rnum;
  assign rnum = word_r >> 2;
  always_comb begin
    if (rnum == 6'd0) begin
      rnd = st_r ^ round_key;
    end else if (rnum == 6'(AES_ROUNDS)) begin
      rnd = agcm_pkg::sub_shift(st_r) ^ round_key;
    end else begin
      rnd = agcm_pkg::mix_columns(agcm_pkg::sub_shift(st_r)) ^ round_key;
    end
  end

  assign gh_start = (state_r == S_HASH);

  agcm_ghash u_ghash (
    .clk(clk), .rst_n(rst_n), .start(gh_start), .x(acc_r ^ ct_r),
    .h({hkh_r, hkl_r}), .done(gh_done), .z(gh_z)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ctr_r       <= '0;
      acc_r       <= '0;
      rd_addr_r   <= '0;
      word_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ob_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          // word 0 is read while idle, so it is ready in the first round cycle
          if (in_ch.valid) begin
            if (ib.op == agcm_pkg::OP_START) begin
              ctr_r <= ib.counter_value;
              acc_r <= {ib.data_high, ib.data_low};
            end else if (ib.op == agcm_pkg::OP_ENCRYPT) begin
              st_r      <= {ivh_r, ivl_r, ctr_r};
              pt_r      <= {ib.data_high, ib.data_low};
              rd_addr_r <= 6'd1;
              word_r    <= '0;
              state_r   <= S_KEY;
            end
          end
        end
        S_KEY: begin
          if (rd_addr_r != 6'(NWORDS - 1)) begin
            rd_addr_r <= rd_addr_r + 6'd1;
          end
          rk_r   <= {rk_r[63:0], agcm_pkg::key_col(rdata)};
          word_r <= word_r + 6'd1;
          if (word_r[1:0] == 2'd3) begin
            st_r <= rnd;
            if (rnum == 6'(AES_ROUNDS)) begin
              ct_r    <= rnd ^ pt_r;
              state_r <= S_HASH;
            end
          end
        end
        S_HASH: begin
          rd_addr_r <= '0;
          state_r   <= S_WAIT;
        end
        S_WAIT: begin
          if (gh_done) begin
            acc_r   <= gh_z;
            ctr_r   <= ctr_r + 32'd1;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (ob_load) begin
            ob_r    <= {ct_r, acc_r};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
